FILE: src/sle_pkg.sv
// Shared types and constants for the sequential list engine.
`default_nettype none

package sle_pkg;

    // Storage geometry.
    localparam int DEPTH      = 128;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Request field widths.
    localparam int MODE_W = 3;
    localparam int POS_W  = 8;

    // Stream word widths.
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 56;

    // Operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_SEARCH = 3'd4
    } t_mode;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_WR   = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // One access to the element memory.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

    // One finished result.
    typedef struct packed {
        logic                  ok;
        logic [ELEM_WIDTH-1:0] element;
        logic [POS_W-1:0]      found_at;
        logic [CNT_W-1:0]      length;
        logic                  empty_res;
        logic                  full_res;
    } t_res;

endpackage

`default_nettype wire

FILE: src/sle_mem.sv
// Element store: one write port and one read port with registered read data.
`default_nettype none

module sle_mem
    import sle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_mem_req              i_req,
    output logic [ELEM_WIDTH-1:0]      o_rdata
);

    logic [ELEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/sle_ctrl.sv
// Request sequencer: checks ranges, walks the memory for shifts and searches.
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    output logic                       o_req_ready,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic [ELEM_WIDTH-1:0] i_value,
    output t_mem_req                   o_mem,
    input  wire logic [ELEM_WIDTH-1:0] i_rdata,
    output logic                       o_res_valid,
    output t_res                       o_res,
    input  wire logic                  i_res_take
);

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [ELEM_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_first, n_first;
    logic                  r_ok, n_ok;
    logic [ELEM_WIDTH-1:0] r_elem, n_elem;
    logic [POS_W-1:0]      r_found, n_found;

    logic             w_accept;
    logic [CNT_W-1:0] w_pos_in;
    logic             w_pos_ok;
    logic             w_ins_ok;
    logic [CNT_W-1:0] w_idx_m1;
    logic [CNT_W-1:0] w_idx_p1;
    logic             w_match;
    logic             w_ins_put;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_pos_in    = CNT_W'(i_position);
    assign w_pos_ok    = (w_pos_in != '0) && (w_pos_in <= r_count);
    assign w_ins_ok    = (r_count < CNT_W'(DEPTH)) && (w_pos_in <= r_count);
    assign w_idx_m1    = r_idx - CNT_W'(1);
    assign w_idx_p1    = r_idx + CNT_W'(1);
    assign w_match     = (i_rdata == r_val);
    assign w_ins_put   = (r_idx == r_pos);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_GET, MODE_REMOVE: n_state = w_pos_ok ? S_RD : S_DONE;
                        MODE_INSERT:           n_state = w_ins_ok ? S_RD : S_DONE;
                        MODE_SEARCH:           n_state = (r_count != '0) ? S_RD : S_DONE;
                        default:               n_state = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                if (r_mode == MODE_INSERT && w_ins_put) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                case (r_mode)
                    MODE_REMOVE: n_state = (w_idx_p1 == r_count) ? S_DONE : S_RD;
                    MODE_SEARCH: n_state = (w_match || w_idx_p1 == r_count) ? S_DONE : S_RD;
                    MODE_INSERT: n_state = S_RD;
                    default:     n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates and memory accesses.
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_val   = r_val;
        n_idx   = r_idx;
        n_count = r_count;
        n_first = r_first;
        n_ok    = r_ok;
        n_elem  = r_elem;
        n_found = r_found;
        o_mem   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_mode;
                    n_pos   = w_pos_in;
                    n_val   = i_value;
                    n_first = 1'b1;
                    n_ok    = 1'b0;
                    n_elem  = '0;
                    n_found = '0;
                    n_idx   = '0;
                    case (i_mode)
                        MODE_GET, MODE_REMOVE: begin
                            n_idx = w_pos_in - CNT_W'(1);
                            n_ok  = w_pos_ok;
                        end
                        MODE_SET: begin
                            // Set finishes in the accept cycle.
                            o_mem.we    = w_pos_ok;
                            o_mem.waddr = ADDR_W'(w_pos_in - CNT_W'(1));
                            o_mem.wdata = i_value;
                            n_ok        = w_pos_ok;
                        end
                        MODE_INSERT: begin
                            n_idx = r_count;
                            n_ok  = w_ins_ok;
                        end
                        MODE_SEARCH: begin
                            n_ok = 1'b1;
                        end
                        default: n_ok = 1'b0;
                    endcase
                end
            end
            S_RD: begin
                if (r_mode == MODE_INSERT && w_ins_put) begin
                    // Gap is open at the insert point: drop the new value in.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = ADDR_W'(r_pos);
                    o_mem.wdata = r_val;
                    n_count     = r_count + CNT_W'(1);
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = (r_mode == MODE_INSERT) ? ADDR_W'(w_idx_m1) : ADDR_W'(r_idx);
                end
            end
            S_WR: begin
                case (r_mode)
                    MODE_GET: n_elem = i_rdata;
                    MODE_INSERT: begin
                        // Move one element up by one place.
                        o_mem.we    = 1'b1;
                        o_mem.waddr = ADDR_W'(r_idx);
                        o_mem.wdata = i_rdata;
                        n_idx       = w_idx_m1;
                    end
                    MODE_REMOVE: begin
                        if (r_first) begin
                            n_elem  = i_rdata;
                            n_first = 1'b0;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = ADDR_W'(w_idx_m1);
                            o_mem.wdata = i_rdata;
                        end
                        n_idx = w_idx_p1;
                        if (w_idx_p1 == r_count) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    MODE_SEARCH: begin
                        if (w_match) begin
                            n_found = POS_W'(w_idx_p1);
                        end
                        n_idx = w_idx_p1;
                    end
                    default: n_elem = r_elem;
                endcase
            end
            S_DONE: begin
                n_ok = r_ok;
            end
            default: n_ok = r_ok;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_first <= n_first;
        r_ok    <= n_ok;
        r_elem  <= n_elem;
        r_found <= n_found;
    end

    // Result of the finished request.
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.ok        = r_ok;
    assign o_res.element   = r_elem;
    assign o_res.found_at  = r_found;
    assign o_res.length    = r_count;
    assign o_res.empty_res = (r_count == '0);
    assign o_res.full_res  = (r_count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

FILE: src/sequential_list_engine.sv
// Top level of the sequential list engine: stream ports, sequencer, store.
//
// A bounded list of up to 128 elements of 32 bits. Requests arrive on the
// s_axis channel with the operation code in tuser (get, set, insert after,
// remove, search) and position and value in tdata. Each request gives one
// result on the m_axis channel with the status, the element read or taken
// out, the search hit, the length and the empty and full flags.
// One request is worked on at a time. The element memory is read and
// written in alternate states (S_RD, then S_WR) for each element that a
// request reads; insert needs one more S_RD visit to place the new value.
// The result moves from S_DONE into the output register, and so onto
// m_axis, on the same edge that returns the sequencer to idle.
// The result sits in an output register; the next request is taken while
// it waits. If the receiver stalls, a second finished result holds the
// sequencer until the output register is free.
// Reset clears the length and the sequencer; element contents are not
// cleared and are only read after they were written.
`default_nettype none

module sequential_list_engine
    import sle_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // position[7:0], value[39:8]
    input  wire logic [S_USER_W-1:0] s_axis_tuser,  // mode[2:0]
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata   // ok, element, found_at, length,
                                                    // empty_res, full_res, zero pad
);

    t_mem_req              w_mem;
    logic [ELEM_WIDTH-1:0] w_rdata;
    logic                  w_res_valid;
    t_res                  w_res;
    logic                  w_res_take;
    logic                  r_out_valid;
    t_res                  r_out;

    // Request sequencer.
    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_mode      (s_axis_tuser[MODE_W-1:0]),
        .i_position  (s_axis_tdata[POS_W-1:0]),
        .i_value     (s_axis_tdata[POS_W +: ELEM_WIDTH]),
        .o_mem       (w_mem),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    // Element store.
    sle_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // Output register: loads when empty or being drained.
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'({r_out.full_res, r_out.empty_res, r_out.length,
                                      r_out.found_at, r_out.element, r_out.ok});

    // The sequencer takes no new request right after taking one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while the previous one was in progress");

    // The length never exceeds the list capacity.
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.length <= CNT_W'(DEPTH)))
        else $error("result length beyond capacity");

    // Empty and full flags follow the length.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_out.empty_res == (r_out.length == '0)) &&
                           (r_out.full_res == (r_out.length == CNT_W'(DEPTH)))))
        else $error("empty or full flag disagrees with length");

    // A search hit always lies inside the list.
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.found_at != '0) |-> (CNT_W'(r_out.found_at) <= r_out.length))
        else $error("search hit beyond the list length");

endmodule

`default_nettype wire

FILE: tb/sequential_list_engine_tb.sv
// Self-checking testbench for the sequential list engine with a built-in list predictor.
`default_nettype none

module sequential_list_engine_tb;
    import sle_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // One expected result, in the order of the output word fields.
    typedef struct packed {
        logic        ok;
        logic [31:0] element;
        logic [7:0]  found_at;
        logic [7:0]  length;
        logic        empty_f;
        logic        full_f;
    } list_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // position[7:0], value[39:8]
    logic [S_USER_W-1:0] s_axis_tuser  = '0;  // mode[2:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // ok[0], element[32:1], found_at[40:33],
                                              // length[48:41], empty[49], full[50]

    // Predicted list contents and length.
    logic [31:0]  list_mem [DEPTH];
    int unsigned  list_len = 0;

    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           quiet          = 1'b0;
    bit           hold_request   = 1'b0;

    sequential_list_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Element values: small values for repeats, the extremes, and full-range values.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 32'($urandom_range(0, 3));
        if (r < 30) return 32'h0000_0000;
        if (r < 35) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Apply one request to the predicted list and return the result it gives.
    task automatic apply_list_request(input logic [2:0] mode, input logic [7:0] pos,
                                      input logic [31:0] value, output list_result_t res);
        int unsigned p;
        int unsigned j;
        res = '0;
        p = pos;
        case (mode)
            MODE_GET: begin
                if (p >= 1 && p <= list_len) begin
                    res.element = list_mem[p-1];
                    res.ok      = 1'b1;
                end
            end
            MODE_SET: begin
                if (p >= 1 && p <= list_len) begin
                    list_mem[p-1] = value;
                    res.ok        = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (list_len < DEPTH && p <= list_len) begin
                    for (j = list_len; j > p; j--)
                        list_mem[j] = list_mem[j-1];
                    list_mem[p] = value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (p >= 1 && p <= list_len) begin
                    res.element = list_mem[p-1];
                    for (j = p; j < list_len; j++)
                        list_mem[j-1] = list_mem[j];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            MODE_SEARCH: begin
                for (j = 0; j < list_len && res.found_at == 0; j++)
                    if (list_mem[j] == value) res.found_at = 8'(j + 1);
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length  = 8'(list_len);
        res.empty_f = (list_len == 0);
        res.full_f  = (list_len == DEPTH);
    endtask

    // Offer one request, wait for its handshake, then record what it should give.
    task automatic send_request(input logic [2:0] mode, input logic [7:0] pos,
                                input logic [31:0] value);
        int           gap;
        list_result_t exp;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {value, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_list_request(mode, pos, value, exp);
        pending_results.push_back(exp);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // A position inside the list, or now and then any 8-bit position.
    function automatic logic [7:0] pick_position(input int unsigned lowest);
        if (list_len < lowest || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(lowest, list_len));
    endfunction

    // Short directed run over the corner cases of every operation.
    task automatic test_directed();
        send_request(MODE_GET,    8'd1,   32'h0);
        send_request(MODE_SET,    8'd1,   32'h1234_5678);
        send_request(MODE_REMOVE, 8'd1,   32'h0);
        send_request(MODE_SEARCH, 8'd0,   32'h0);
        send_request(MODE_INSERT, 8'd1,   32'hAAAA_AAAA);
        send_request(3'd5,        8'd0,   32'h0);
        send_request(3'd6,        8'd255, 32'hFFFF_FFFF);
        send_request(3'd7,        8'd1,   32'h5555_5555);
        send_request(MODE_INSERT, 8'd0,   32'h0000_0000);
        send_request(MODE_INSERT, 8'd1,   32'hFFFF_FFFF);
        send_request(MODE_INSERT, 8'd0,   32'h5A5A_A5A5);
        send_request(MODE_GET,    8'd1,   32'h0);
        send_request(MODE_GET,    8'd3,   32'h0);
        send_request(MODE_GET,    8'd0,   32'h0);
        send_request(MODE_GET,    8'd4,   32'h0);
        send_request(MODE_GET,    8'd255, 32'h0);
        send_request(MODE_SET,    8'd3,   32'hFFFF_FFFF);
        send_request(MODE_SET,    8'd4,   32'h1);
        send_request(MODE_SEARCH, 8'd0,   32'hFFFF_FFFF);
        send_request(MODE_SEARCH, 8'd255, 32'hDEAD_BEEF);
        send_request(MODE_INSERT, 8'd5,   32'h7);
        send_request(MODE_REMOVE, 8'd3,   32'h0);
        send_request(MODE_REMOVE, 8'd0,   32'h0);
        send_request(MODE_REMOVE, 8'd1,   32'h0);
        send_request(MODE_REMOVE, 8'd1,   32'h0);
    endtask

    // Fill the list to capacity, probe the full list, then empty it again.
    task automatic test_fill_and_drain();
        while (list_len < DEPTH)
            send_request(MODE_INSERT, 8'($urandom_range(0, list_len)), pick_value());
        send_request(MODE_INSERT, 8'd0,   32'h1);
        send_request(MODE_INSERT, 8'd128, 32'h2);
        send_request(MODE_SEARCH, 8'd0,   list_mem[DEPTH-1]);
        send_request(MODE_SEARCH, 8'd0,   32'hDEAD_BEEF);
        send_request(MODE_GET,    8'd128, 32'h0);
        send_request(MODE_SET,    8'd128, 32'hC0DE_0128);
        send_request(MODE_GET,    8'd129, 32'h0);
        send_request(MODE_REMOVE, 8'd129, 32'h0);
        send_request(MODE_REMOVE, 8'd128, 32'h0);
        while (list_len > 0)
            send_request(MODE_REMOVE, 8'($urandom_range(1, list_len)), 32'($urandom));
    endtask

    // Random mix of operations, steered so that the length wanders over its range.
    task automatic test_random_mix(input int n_items);
        int          r;
        int          ins_w;
        int          rem_w;
        logic [31:0] key;
        for (int i = 0; i < n_items; i++) begin
            quiet = ((i / 100) % 4 == 3);
            if (list_len < 20) begin
                ins_w = 45; rem_w = 8;
            end else if (list_len > 110) begin
                ins_w = 8; rem_w = 45;
            end else begin
                ins_w = 25; rem_w = 25;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_request(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                             8'($urandom_range(0, 255)), $urandom);
            end else if (r < 3 + ins_w) begin
                send_request(MODE_INSERT, pick_position(0), pick_value());
            end else if (r < 3 + ins_w + rem_w) begin
                send_request(MODE_REMOVE, pick_position(1), $urandom);
            end else if (r < 3 + ins_w + rem_w + 15) begin
                if (list_len > 0 && $urandom_range(0, 2) != 0)
                    key = list_mem[$urandom_range(0, list_len - 1)];
                else
                    key = pick_value();
                send_request(MODE_SEARCH, 8'($urandom_range(0, 255)), key);
            end else if ($urandom_range(0, 1) == 0) begin
                send_request(MODE_GET, pick_position(1), $urandom);
            end else begin
                send_request(MODE_SET, pick_position(1), pick_value());
            end
        end
        quiet = 1'b0;
    endtask

    // Hold the output off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        quiet        = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if (list_len < DEPTH && $urandom_range(0, 1) == 0)
                send_request(MODE_INSERT, 8'($urandom_range(0, list_len)), pick_value());
            else
                send_request(MODE_GET, pick_position(1), 32'h0);
        end
        quiet = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold when asked for.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet) stall_left = pick_gap();
            end
        end
    end

    // Count one mismatching field and report the first ten.
    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, exp_v, act_v);
    endtask

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        list_result_t exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, m_axis_tdata[31:0]);
            end else begin
                exp = pending_results.pop_front();
                if (m_axis_tdata[0] !== exp.ok)
                    report_mismatch("ok", 32'(exp.ok), 32'(m_axis_tdata[0]));
                if (m_axis_tdata[32:1] !== exp.element)
                    report_mismatch("element", exp.element, m_axis_tdata[32:1]);
                if (m_axis_tdata[40:33] !== exp.found_at)
                    report_mismatch("found_at", 32'(exp.found_at), 32'(m_axis_tdata[40:33]));
                if (m_axis_tdata[48:41] !== exp.length)
                    report_mismatch("length", 32'(exp.length), 32'(m_axis_tdata[48:41]));
                if (m_axis_tdata[49] !== exp.empty_f)
                    report_mismatch("empty_res", 32'(exp.empty_f), 32'(m_axis_tdata[49]));
                if (m_axis_tdata[50] !== exp.full_f)
                    report_mismatch("full_res", 32'(exp.full_f), 32'(m_axis_tdata[50]));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_random_mix(470);
        test_output_backpressure();
        test_random_mix(470);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
